// ===== hw/rtl/lfe_pkg.sv =====
// lfe_pkg: types and constants shared by the line folding escape encoder.
// No dependencies.
`default_nettype none

package lfe_pkg;

   localparam logic [7:0] WRAP_RESET = 8'd74;
   localparam logic [7:0] COLUMN_MAX = 8'hFF;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_BSL  = 8'h5C;
   localparam logic [7:0] CHAR_N    = 8'h6E;
   localparam logic [7:0] CHAR_NONE = 8'h00;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ESCAPE,
      KIND_NEWLINE,
      KIND_PLAIN
   } kind_type;

   typedef struct packed {
      logic       fold;
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lfe_req_if.sv =====
// lfe_req_if: input item channel, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface lfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_text;
   logic       last_of_text;
   logic [7:0] start_column;

   modport source (output valid, data_byte, first_of_text, last_of_text, start_column,
                   input ready);
   modport sink   (input valid, data_byte, first_of_text, last_of_text, start_column,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfe_rsp_if.sv =====
// lfe_rsp_if: result item channel, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface lfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last_of_run;
   logic       end_of_text;

   modport source (output valid, out_byte, byte_valid, last_of_run, end_of_text,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last_of_run, end_of_text,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfe_front.sv =====
// lfe_front: accepts items, tracks the column, decides fold and escape kind.
// Depends on lfe_pkg and lfe_req_if.
`default_nettype none

module lfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   lfe_req_if.sink              req,
   input  wire logic [7:0]      wrap_column,
   input  wire logic            queue_full,
   output lfe_pkg::cmd_type     push_cmd,
   output logic                 push
);

   logic [7:0]        column_ff;
   logic [7:0]        column_in;
   logic [7:0]        col_cur;
   logic [7:0]        col_base;
   logic [8:0]        col_sum;
   logic [1:0]        advance;
   logic              fold;
   logic              accept;
   lfe_pkg::kind_type kind;

   always_comb begin
      if (req.data_byte == lfe_pkg::CHAR_EQ || req.data_byte[7]) begin
         kind    = lfe_pkg::KIND_ESCAPE;
         advance = 2'd3;
      end else if (req.data_byte == lfe_pkg::CHAR_LF) begin
         kind    = lfe_pkg::KIND_NEWLINE;
         advance = 2'd2;
      end else if (req.data_byte == lfe_pkg::CHAR_CR) begin
         kind    = lfe_pkg::KIND_NONE;
         advance = 2'd0;
      end else begin
         kind    = lfe_pkg::KIND_PLAIN;
         advance = 2'd1;
      end
   end

   assign col_cur   = req.first_of_text ? req.start_column : column_ff;
   assign fold      = (col_cur >= wrap_column);
   assign col_base  = fold ? 8'd0 : col_cur;
   assign col_sum   = {1'b0, col_base} + {7'd0, advance};
   assign column_in = col_sum[8] ? lfe_pkg::COLUMN_MAX : col_sum[7:0];

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign push      = accept && (fold || kind != lfe_pkg::KIND_NONE || req.last_of_text);

   assign push_cmd.fold = fold;
   assign push_cmd.kind = kind;
   assign push_cmd.data = req.data_byte;
   assign push_cmd.last = req.last_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
      end else if (accept) begin
         column_ff <= column_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfe_queue.sv =====
// lfe_queue: small FIFO of commands between front and back.
// Depends on lfe_pkg.
`default_nettype none

module lfe_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lfe_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output lfe_pkg::cmd_type      head_cmd,
   output logic                  not_empty,
   output logic                  full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   lfe_pkg::cmd_type  entries [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entries[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfe_back.sv =====
// lfe_back: expands one command into its result items, one per cycle while rsp is
// ready, through an output register. Depends on lfe_pkg and lfe_rsp_if.
`default_nettype none

module lfe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lfe_pkg::cmd_type head_cmd,
   input  wire logic             cmd_valid,
   output logic                  pop,
   lfe_rsp_if.source             rsp
);

   logic [2:0] step_ff, step_in;
   logic [2:0] n_fold;
   logic [2:0] n_char;
   logic [2:0] n_total;
   logic [2:0] char_step;
   logic       last_step;
   logic       load;
   logic [7:0] byte_sel;
   logic       marker;

   logic       rsp_valid_ff,   rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       byte_valid_ff;
   logic       last_of_run_ff;
   logic       end_of_text_ff;

   assign marker = !head_cmd.fold && head_cmd.kind == lfe_pkg::KIND_NONE;

   always_comb begin
      n_fold = head_cmd.fold ? 3'd3 : 3'd0;
      unique case (head_cmd.kind)
         lfe_pkg::KIND_ESCAPE:  n_char = 3'd3;
         lfe_pkg::KIND_NEWLINE: n_char = 3'd2;
         lfe_pkg::KIND_PLAIN:   n_char = 3'd1;
         default:               n_char = 3'd0;
      endcase
      n_total   = n_fold + n_char;
      last_step = marker || (step_ff == n_total - 3'd1);
      char_step = step_ff - n_fold;
   end

   always_comb begin
      byte_sel = lfe_pkg::CHAR_NONE;
      if (step_ff < n_fold) begin
         unique case (step_ff[1:0])
            2'd0:    byte_sel = lfe_pkg::CHAR_CR;
            2'd1:    byte_sel = lfe_pkg::CHAR_LF;
            default: byte_sel = lfe_pkg::CHAR_TAB;
         endcase
      end else begin
         unique case (head_cmd.kind)
            lfe_pkg::KIND_ESCAPE: begin
               if (char_step == 3'd0) begin
                  byte_sel = lfe_pkg::CHAR_EQ;
               end else if (char_step == 3'd1) begin
                  byte_sel = lfe_pkg::HEX_DIGITS[head_cmd.data[7:4]];
               end else begin
                  byte_sel = lfe_pkg::HEX_DIGITS[head_cmd.data[3:0]];
               end
            end
            lfe_pkg::KIND_NEWLINE: begin
               byte_sel = (char_step == 3'd0) ? lfe_pkg::CHAR_BSL : lfe_pkg::CHAR_N;
            end
            lfe_pkg::KIND_PLAIN: byte_sel = head_cmd.data;
            default:             byte_sel = lfe_pkg::CHAR_NONE;
         endcase
      end
   end

   assign load = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && last_step;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         step_in      = last_step ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff    <= byte_sel;
         byte_valid_ff  <= !marker;
         last_of_run_ff <= last_step;
         end_of_text_ff <= last_step && head_cmd.last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.byte_valid  = byte_valid_ff;
   assign rsp.last_of_run = last_of_run_ff;
   assign rsp.end_of_text = end_of_text_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/line_folding_escape_encoder_core.sv =====
// line_folding_escape_encoder_core: top level, wrap register, front, queue, back.
// Depends on lfe_pkg, lfe_req_if, lfe_rsp_if, lfe_front, lfe_queue, lfe_back.
//
//   channel  dir  handshake       payload
//   req_ch   in   valid/ready     data_byte, first_of_text, last_of_text, start_column
//   rsp_ch   out  valid/ready     out_byte, byte_valid, last_of_run, end_of_text
//   csr      in   csr_wr_en       csr_wr_data (wrap_column)
//
// Plain bytes: one item per cycle while rsp is ready. An item yields 0 to 6 result
// items (none for a dropped CR that neither folds nor ends the text), one per cycle
// from the back end's step counter unless stalled; the front takes items until the
// command queue (QUEUE_DEPTH entries) fills; results pass queue, then output register.
// Reset clears column, queue and output register; wrap_column returns to 74.
// Either side may stall freely; the output register holds its item while stalled.
`default_nettype none

module line_folding_escape_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   lfe_req_if.sink         req_ch,
   lfe_rsp_if.source       rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [7:0]       wrap_column_ff;
   lfe_pkg::cmd_type push_cmd;
   lfe_pkg::cmd_type head_cmd;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_not_empty;
   logic [CW-1:0]    queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_column_ff <= lfe_pkg::WRAP_RESET;
      end else if (csr_wr_en) begin
         wrap_column_ff <= csr_wr_data;
      end
   end

   lfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .wrap_column (wrap_column_ff),
      .queue_full  (queue_full),
      .push_cmd    (push_cmd),
      .push        (push)
   );

   lfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .count     (queue_count)
   );

   lfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .cmd_valid (queue_not_empty),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= CW'(QUEUE_DEPTH))
      else $error("queue count past depth");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.end_of_text |-> rsp_ch.last_of_run)
      else $error("end_of_text without last_of_run");

   a_marker_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.end_of_text)
      else $error("empty result item not at end of text");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/line_folding_escape_encoder_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_folding_escape_encoder_core: a scoreboard
// class predicts the folded, escaped characters of every accepted item.
// Depends on lfe_pkg, lfe_req_if, lfe_rsp_if and the core itself.

module line_folding_escape_encoder_core_tb;

   localparam int          MAX_REPORTS    = 10;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          HOLDOFF_CYCLES = 120;
   localparam int          PHASE_ITEMS    = 63;
   localparam int unsigned CYCLE_LIMIT    = 150000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       end_of_text;
   } enc_char_type;

   class folded_line_scoreboard;
      logic [7:0]   wrap_column;
      logic [7:0]   column;
      enc_char_type pending[$];
      int           mismatches;
      int           items_taken;
      int           chars_checked;

      function new();
         wrap_column   = lfe_pkg::WRAP_RESET;
         column        = 8'd0;
         mismatches    = 0;
         items_taken   = 0;
         chars_checked = 0;
      endfunction

      function enc_char_type text_char(logic [7:0] c);
         text_char = '{c, 1'b1, 1'b0, 1'b0};
      endfunction

      function void advance(int unsigned amount);
         int unsigned next_col;
         next_col = column + amount;
         column   = (next_col > lfe_pkg::COLUMN_MAX) ? lfe_pkg::COLUMN_MAX : next_col[7:0];
      endfunction

      // Predicts the characters one accepted item yields and queues them.
      function void take_input(logic [7:0] data, logic first, logic last,
                               logic [7:0] start);
         enc_char_type run[$];
         items_taken++;
         if (first)
            column = start;
         if (column >= wrap_column) begin
            run.push_back(text_char(lfe_pkg::CHAR_CR));
            run.push_back(text_char(lfe_pkg::CHAR_LF));
            run.push_back(text_char(lfe_pkg::CHAR_TAB));
            column = 8'd0;
         end
         if (data == lfe_pkg::CHAR_EQ || data[7]) begin
            run.push_back(text_char(lfe_pkg::CHAR_EQ));
            run.push_back(text_char(lfe_pkg::HEX_DIGITS[data[7:4]]));
            run.push_back(text_char(lfe_pkg::HEX_DIGITS[data[3:0]]));
            advance(3);
         end else if (data == lfe_pkg::CHAR_LF) begin
            run.push_back(text_char(lfe_pkg::CHAR_BSL));
            run.push_back(text_char(lfe_pkg::CHAR_N));
            advance(2);
         end else if (data != lfe_pkg::CHAR_CR) begin
            run.push_back(text_char(data));
            advance(1);
         end
         if (run.size() == 0) begin
            if (last)
               pending.push_back('{lfe_pkg::CHAR_NONE, 1'b0, 1'b1, 1'b1});
            return;
         end
         run[run.size() - 1].last_of_run = 1'b1;
         run[run.size() - 1].end_of_text = last;
         foreach (run[i])
            pending.push_back(run[i]);
      endfunction

      function void report(string what, enc_char_type want, enc_char_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s: expected byte %h valid %b run_end %b text_end %b",
                     $time, what, want.out_byte, want.byte_valid, want.last_of_run,
                     want.end_of_text);
            $display("    got byte %h valid %b run_end %b text_end %b",
                     got.out_byte, got.byte_valid, got.last_of_run, got.end_of_text);
         end
      endfunction

      function void check_char(enc_char_type got);
         enc_char_type want;
         if (pending.size() == 0) begin
            report("unexpected item", '0, got);
            return;
         end
         want = pending.pop_front();
         chars_checked++;
         if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
             got.last_of_run !== want.last_of_run || got.end_of_text !== want.end_of_text)
            report("wrong item", want, got);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   lfe_req_if req_ch ();
   lfe_rsp_if rsp_ch ();

   line_folding_escape_encoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   folded_line_scoreboard sb = new();

   int          send_idle_pct    = 0;
   int          recv_stall_pct   = 0;
   int          holdoff_requests = 0;
   int          wrap_writes      = 0;
   int unsigned cycle_count      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: random stalls plus long hold-offs on request.
   initial begin
      int holdoffs_served;
      int holdoff_left;
      holdoffs_served = 0;
      holdoff_left    = 0;
      rsp_ch.ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_served != holdoff_requests) begin
            holdoffs_served++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.take_input(req_ch.data_byte, req_ch.first_of_text, req_ch.last_of_text,
                          req_ch.start_column);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_char('{rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.last_of_run,
                            rsp_ch.end_of_text});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items still expected",
                  cycle_count, sb.pending.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Starts and ends at a falling edge; valid stays high into the next item.
   task automatic send_item(input logic [7:0] data, input logic first, input logic last,
                            input logic [7:0] start);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= data;
      req_ch.first_of_text <= first;
      req_ch.last_of_text  <= last;
      req_ch.start_column  <= start;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Called at a falling edge; drops valid and waits for every expected item.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_wrap(input logic [7:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.wrap_column = value;
      wrap_writes++;
   endtask

   function automatic logic [7:0] pick_text_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55)
         return 8'($urandom_range(8'h20, 8'h7E));
      else if (r < 65)
         return lfe_pkg::CHAR_EQ;
      else if (r < 75)
         return lfe_pkg::CHAR_LF;
      else if (r < 83)
         return lfe_pkg::CHAR_CR;
      else
         return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] pick_start();
      int unsigned r;
      int unsigned lo;
      r  = $urandom_range(99);
      lo = (sb.wrap_column > 10) ? sb.wrap_column - 10 : 0;
      if (r < 40)
         return 8'($urandom_range(lo, sb.wrap_column));
      else if (r < 65)
         return 8'($urandom_range(0, 20));
      else if (r < 90)
         return 8'($urandom_range(0, 255));
      else if (r < 95)
         return 8'hFF;
      else
         return 8'h00;
   endfunction

   // One text value; broken texts carry random flags and start columns.
   task automatic send_text(output int sent);
      int         len;
      logic       broken;
      logic [7:0] start;
      len    = $urandom_range(1, 16);
      broken = ($urandom_range(7) == 0);
      start  = pick_start();
      for (int i = 0; i < len; i++) begin
         if (broken)
            send_item(pick_text_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(0, 255)));
         else
            send_item(pick_text_byte(), i == 0, i == len - 1, start);
      end
      sent = len;
   endtask

   task automatic run_phase(input logic [7:0] wrap, input int send_pct, input int recv_pct,
                            input logic with_holdoff);
      int total;
      int sent;
      total = 0;
      write_wrap(wrap);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      while (total < PHASE_ITEMS) begin
         if (with_holdoff && total >= 15 && total - sent < 15)
            holdoff_requests++;
         send_text(sent);
         total += sent;
      end
   endtask

   task automatic run_directed();
      // reset wrap of 74: escapes, newline, dropped CR, fold before escape
      send_item(8'h41, 1'b1, 1'b0, 8'd72);
      send_item(lfe_pkg::CHAR_EQ, 1'b0, 1'b0, 8'd0);
      send_item(8'hFF, 1'b0, 1'b0, 8'd0);
      send_item(lfe_pkg::CHAR_LF, 1'b0, 1'b0, 8'd0);
      send_item(lfe_pkg::CHAR_CR, 1'b0, 1'b0, 8'd0);
      send_item(8'h7F, 1'b0, 1'b0, 8'd0);
      send_item(8'h80, 1'b0, 1'b0, 8'd0);
      send_item(8'h01, 1'b0, 1'b0, 8'd0);
      send_item(lfe_pkg::CHAR_CR, 1'b0, 1'b1, 8'd0);
      // final CR that folds, then a text without a first byte
      send_item(lfe_pkg::CHAR_CR, 1'b1, 1'b1, 8'hFF);
      send_item(8'h7A, 1'b0, 1'b1, 8'd0);
      send_item(8'h40, 1'b1, 1'b1, 8'd0);
      // widest wrap: column saturation, then fold at 255
      write_wrap(8'hFF);
      send_item(lfe_pkg::CHAR_EQ, 1'b1, 1'b0, 8'd254);
      send_item(8'hAA, 1'b0, 1'b0, 8'd0);
      send_item(8'h7E, 1'b1, 1'b1, 8'hFF);
      // narrowest wrap: a fold before nearly every byte
      write_wrap(8'd1);
      send_item(8'h61, 1'b1, 1'b0, 8'd0);
      send_item(lfe_pkg::CHAR_LF, 1'b0, 1'b0, 8'd0);
      send_item(8'hC3, 1'b0, 1'b0, 8'd0);
      send_item(lfe_pkg::CHAR_CR, 1'b0, 1'b1, 8'd0);
      send_item(lfe_pkg::CHAR_CR, 1'b1, 1'b1, 8'd0);
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 8'd0;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = 8'd0;
      req_ch.first_of_text = 1'b0;
      req_ch.last_of_text  = 1'b0;
      req_ch.start_column  = 8'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(8'd74, 0, 0, 1'b1);
      run_phase(8'hFF, 54, 0, 1'b0);
      run_phase(8'd1, 0, 54, 1'b0);
      run_phase(8'($urandom_range(1, 255)), 6, 6, 1'b0);
      run_phase(8'($urandom_range(2, 20)), 54, 0, 1'b0);
      run_phase(8'($urandom_range(1, 255)), 0, 54, 1'b1);
      drain();

      $display("Summary: %0d input items, %0d result items checked, %0d wrap settings",
               sb.items_taken, sb.chars_checked, wrap_writes);
      $display("Covered no idling, idle sender, stalling receiver, both, and long hold-offs");
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
